>>> sv/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, codes and command/status types for the PUCT child selector.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int PRIOR_W = 16;
    localparam int PVIS_W  = 20;
    localparam int VSUM_W  = 37;
    localparam int SQRT_W  = 18;
    localparam int SCORE_W = 28;
    localparam int INDEX_W = 6;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef struct packed {
        logic load;        // capture the input beat
        logic sqrt_start;  // start the square root
        logic div_start;   // start both divisions
        logic update;      // compare and keep best
        logic clear_run;   // return running best to its start value
    } pcs_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } pcs_status_t;

endpackage

>>> sv/puct_child_select.sv
// ----------------------------------------------------------------------------
// puct_child_select
// PUCT child selection over the children of one search node.
// ----------------------------------------------------------------------------
// Children arrive one beat each on the input channel (valid/ready) with the
// parent's visit count; last_child marks the final child of a node. For each
// child the score prior*sqrt(N)/(n+1) - value_sum/n is formed and the best
// score and position are kept, earlier children winning ties. After the last
// child one beat with best_index and pick_score leaves on the output channel.
// The operands are registered when the beat is taken and in_ready stays low
// while the child is scored: every scored child waits for the 37-step serial
// division, and the first child of a node first waits for the bit-serial
// square root. Children beyond the position limit skip both and go straight
// to the update state. The result register lets the next node's children
// proceed while a result waits; only when the next result is due with the
// previous one still stalled by out_ready does the sequencer stop, and input
// stalls with it. Reset clears the sequencer, the running best and the stored
// square root.
// ----------------------------------------------------------------------------
module puct_child_select #(
    parameter int MAX_CHILDREN = 64,
    parameter int VISIT_BITS   = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pcs_pkg::PVIS_W-1:0]         parent_visits,
    input  logic [pcs_pkg::PRIOR_W-1:0]        child_prior,
    input  logic [pcs_pkg::PVIS_W-1:0]         child_visits,
    input  logic signed [pcs_pkg::VSUM_W-1:0]  child_value_sum,
    input  logic                               last_child,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pcs_pkg::INDEX_W-1:0]        best_index,
    output logic signed [pcs_pkg::SCORE_W-1:0] pick_score
);
    localparam int POS_W = $clog2(MAX_CHILDREN + 1);

    pcs_pkg::pcs_cmd_t    cmd;
    pcs_pkg::pcs_status_t status;
    logic [POS_W-1:0]     position;
    logic                 capture;
    logic [pcs_pkg::INDEX_W-1:0]        dp_index;
    logic signed [pcs_pkg::SCORE_W-1:0] dp_score;
    logic [pcs_pkg::INDEX_W-1:0]        idx_reg;
    logic signed [pcs_pkg::SCORE_W-1:0] score_reg;

    pcs_ctrl #(.MAX_CHILDREN(MAX_CHILDREN), .POS_W(POS_W)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .last_child(last_child), .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .status(status), .position(position), .capture(capture)
    );

    pcs_datapath #(.VISIT_BITS(VISIT_BITS), .POS_W(POS_W)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .parent_visits(parent_visits), .child_prior(child_prior),
        .child_visits(child_visits), .child_value_sum(child_value_sum),
        .position(position), .best_index(dp_index), .pick_score(dp_score)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            score_reg <= pcs_pkg::SCORE_MIN;
        end
        else if (capture)
        begin
            idx_reg   <= dp_index;
            score_reg <= dp_score;
        end
    end

    assign best_index = idx_reg;
    assign pick_score = score_reg;
endmodule

>>> sv/pcs_datapath.sv
// ----------------------------------------------------------------------------
// pcs_datapath
// Operand registers, a bit-serial square root, two restoring dividers and
// the running best score and index.
// ----------------------------------------------------------------------------
module pcs_datapath #(
    parameter int VISIT_BITS = 20,
    parameter int POS_W      = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcs_pkg::pcs_cmd_t                      cmd,
    output pcs_pkg::pcs_status_t                   status,
    input  logic [pcs_pkg::PVIS_W-1:0]             parent_visits,
    input  logic [pcs_pkg::PRIOR_W-1:0]            child_prior,
    input  logic [pcs_pkg::PVIS_W-1:0]             child_visits,
    input  logic signed [pcs_pkg::VSUM_W-1:0]      child_value_sum,
    input  logic [POS_W-1:0]                       position,
    output logic [pcs_pkg::INDEX_W-1:0]            best_index,
    output logic signed [pcs_pkg::SCORE_W-1:0]     pick_score
);
    localparam int VW   = (VISIT_BITS < pcs_pkg::PVIS_W) ? VISIT_BITS : pcs_pkg::PVIS_W;
    localparam int RADW = 2 * pcs_pkg::SQRT_W;          // radicand bits
    localparam int NUMW = pcs_pkg::PRIOR_W + pcs_pkg::SQRT_W;
    localparam int DENW = pcs_pkg::PVIS_W + 9;
    localparam int MAGW = pcs_pkg::VSUM_W;
    localparam int SCW  = 6;
    localparam int DCW  = 6;

    logic [pcs_pkg::PVIS_W-1:0] pvis_m, cvis_m;
    always_comb
    begin
        pvis_m = '0;
        cvis_m = '0;
        pvis_m[VW-1:0] = parent_visits[VW-1:0];
        cvis_m[VW-1:0] = child_visits[VW-1:0];
    end

    // Child operands are held here once the beat has been taken.
    logic [pcs_pkg::PRIOR_W-1:0]       prior_reg;
    logic [pcs_pkg::PVIS_W-1:0]        cvis_reg;
    logic signed [pcs_pkg::VSUM_W-1:0] vsum_reg;

    // Square root, two radicand bits per cycle.
    logic [RADW-1:0]              rad_reg, rad_next;
    logic [pcs_pkg::SQRT_W+1:0]   rem_reg, rem_next;
    logic [pcs_pkg::SQRT_W-1:0]   root_reg, root_next;
    logic [SCW-1:0]               scnt_reg, scnt_next;
    logic                         sbusy_reg, sbusy_next;
    logic [pcs_pkg::SQRT_W-1:0]   sqrt_reg, sqrt_next;
    logic [pcs_pkg::SQRT_W+1:0]   trial;
    logic [pcs_pkg::SQRT_W+1:0]   rem_sh;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        scnt_next = scnt_reg;
        sbusy_next = sbusy_reg;
        sqrt_next = sqrt_reg;
        rem_sh = {rem_reg[pcs_pkg::SQRT_W-1:0], rad_reg[RADW-1:RADW-2]};
        trial  = {root_reg, 2'b01};
        if (cmd.sqrt_start)
        begin
            rad_next  = RADW'({pvis_m, 16'd0});
            rem_next  = '0;
            root_next = '0;
            scnt_next = SCW'(pcs_pkg::SQRT_W);
            sbusy_next = 1'b1;
        end
        else if (sbusy_reg)
        begin
            rad_next = {rad_reg[RADW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[pcs_pkg::SQRT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[pcs_pkg::SQRT_W-2:0], 1'b0};
            end
            scnt_next = scnt_reg - SCW'(1);
            if (scnt_reg == SCW'(1))
            begin
                sbusy_next = 1'b0;
                sqrt_next  = root_next;
            end
        end
    end

    // Two dividers run side by side, one quotient bit each per cycle once the prior divider's steps begin.
    logic [NUMW-1:0] pn_reg, pn_next;      // numerator, becomes quotient
    logic [DENW-1:0] pd_reg, pd_next;
    logic [DENW-1:0] pr_reg, pr_next;
    logic [MAGW-1:0] mn_reg, mn_next;
    logic [pcs_pkg::PVIS_W-1:0] md_reg, md_next;
    logic [pcs_pkg::PVIS_W:0]   mr_reg, mr_next;
    logic            mneg_reg, mneg_next, mzero_reg, mzero_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;
    logic            dbusy_reg, dbusy_next;
    logic [DENW:0]   pr_sh;
    logic [pcs_pkg::PVIS_W+1:0] mr_sh;
    logic [MAGW-1:0] mag;

    always_comb
    begin
        pn_next = pn_reg; pd_next = pd_reg; pr_next = pr_reg;
        mn_next = mn_reg; md_next = md_reg; mr_next = mr_reg;
        mneg_next = mneg_reg; mzero_next = mzero_reg;
        dcnt_next = dcnt_reg; dbusy_next = dbusy_reg;
        mag = vsum_reg[MAGW-1] ? MAGW'(-vsum_reg) : vsum_reg;
        pr_sh = {pr_reg, pn_reg[NUMW-1]};
        mr_sh = {mr_reg, mn_reg[MAGW-1]};
        if (cmd.div_start)
        begin
            pn_next = NUMW'(prior_reg) * NUMW'(sqrt_reg);
            pd_next = {DENW'(cvis_reg) + DENW'(1)} << 8;
            pr_next = '0;
            mn_next = mag;
            md_next = cvis_reg;
            mr_next = '0;
            mneg_next  = vsum_reg[MAGW-1];
            mzero_next = (cvis_reg == '0);
            dcnt_next  = DCW'(MAGW);
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            if (dcnt_reg <= DCW'(NUMW))
            begin
                if (pr_sh >= {1'b0, pd_reg})
                begin
                    pr_next = DENW'(pr_sh - {1'b0, pd_reg});
                    pn_next = {pn_reg[NUMW-2:0], 1'b1};
                end
                else
                begin
                    pr_next = DENW'(pr_sh);
                    pn_next = {pn_reg[NUMW-2:0], 1'b0};
                end
            end
            if (mr_sh >= {2'b00, md_reg})
            begin
                mr_next = (pcs_pkg::PVIS_W+1)'(mr_sh - {2'b00, md_reg});
                mn_next = {mn_reg[MAGW-2:0], 1'b1};
            end
            else
            begin
                mr_next = (pcs_pkg::PVIS_W+1)'(mr_sh);
                mn_next = {mn_reg[MAGW-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - DCW'(1);
            if (dcnt_reg == DCW'(1))
                dbusy_next = 1'b0;
        end
    end

    // Score and compare.
    logic signed [MAGW+2:0] mean_s, pterm_s, score_w;
    logic signed [pcs_pkg::SCORE_W-1:0] score;
    logic signed [pcs_pkg::SCORE_W-1:0] bscore_reg, bscore_next;
    logic [pcs_pkg::INDEX_W-1:0]        bidx_reg, bidx_next;

    always_comb
    begin
        mean_s  = mzero_reg ? '0 : (mneg_reg ? -$signed({3'b000, mn_reg})
                                             :  $signed({3'b000, mn_reg}));
        pterm_s = $signed({{(MAGW+3-NUMW){1'b0}}, pn_reg});
        score_w = pterm_s - mean_s;
        if (score_w > (MAGW+3)'(pcs_pkg::SCORE_MAX))
            score = pcs_pkg::SCORE_MAX;
        else if (score_w < $signed((MAGW+3)'(pcs_pkg::SCORE_MIN)))
            score = pcs_pkg::SCORE_MIN;
        else
            score = score_w[pcs_pkg::SCORE_W-1:0];
        bscore_next = bscore_reg;
        bidx_next   = bidx_reg;
        if (cmd.clear_run)
        begin
            bscore_next = pcs_pkg::SCORE_MIN;
            bidx_next   = '0;
        end
        else if (cmd.update && score > bscore_reg)
        begin
            bscore_next = score;
            bidx_next   = pcs_pkg::INDEX_W'(position);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbusy_reg  <= 1'b0;
            dbusy_reg  <= 1'b0;
            scnt_reg   <= '0;
            dcnt_reg   <= '0;
            sqrt_reg   <= '0;
            bscore_reg <= pcs_pkg::SCORE_MIN;
            bidx_reg   <= '0;
        end
        else
        begin
            sbusy_reg  <= sbusy_next;
            dbusy_reg  <= dbusy_next;
            scnt_reg   <= scnt_next;
            dcnt_reg   <= dcnt_next;
            sqrt_reg   <= sqrt_next;
            bscore_reg <= bscore_next;
            bidx_reg   <= bidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next; rem_reg <= rem_next; root_reg <= root_next;
        pn_reg <= pn_next; pd_reg <= pd_next; pr_reg <= pr_next;
        mn_reg <= mn_next; md_reg <= md_next; mr_reg <= mr_next;
        mneg_reg <= mneg_next; mzero_reg <= mzero_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prior_reg <= child_prior;
            cvis_reg  <= cvis_m;
            vsum_reg  <= child_value_sum;
        end
    end

    assign status.sqrt_done = !sbusy_reg;
    assign status.div_done  = !dbusy_reg;
    assign best_index = bidx_reg;
    assign pick_score = bscore_reg;
endmodule

>>> sv/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: accepts a beat, runs square root and divisions, updates the best
// and presents the result of a run.
// ----------------------------------------------------------------------------
module pcs_ctrl #(
    parameter int MAX_CHILDREN = 64,
    parameter int POS_W        = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       last_child,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pcs_pkg::pcs_cmd_t          cmd,
    input  pcs_pkg::pcs_status_t       status,
    output logic [POS_W-1:0]           position,
    output logic                       capture
);
    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_DSTART, S_DIV, S_UPD, S_OUT} state_t;
    state_t state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             last_reg, last_next;
    logic             oval_reg, oval_next;
    logic             scored;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = oval_reg;
    assign position  = pos_reg;
    assign scored    = pos_reg < POS_W'(MAX_CHILDREN);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        oval_next  = oval_reg;
        cmd        = '0;
        capture    = 1'b0;
        if (oval_reg && out_ready)
            oval_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load  = 1'b1;
                    last_next = last_child;
                    if (!scored)
                        state_next = S_UPD;
                    else if (pos_reg == '0)
                    begin
                        cmd.sqrt_start = 1'b1;
                        state_next = S_SQRT;
                    end
                    else
                        state_next = S_DSTART;
                end
            end
            S_SQRT:
                if (status.sqrt_done)
                    state_next = S_DSTART;
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
                if (status.div_done)
                    state_next = S_UPD;
            S_UPD:
            begin
                if (scored)
                begin
                    cmd.update = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                end
                state_next = last_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                // The result register is reloaded only once its previous beat has gone.
                if (!oval_reg || out_ready)
                begin
                    capture = 1'b1;
                    oval_next = 1'b1;
                    cmd.clear_run = 1'b1;
                    pos_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            last_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
            oval_reg  <= oval_next;
        end
    end
endmodule
